// File: hw/rtl/mtgl_pkg.sv
package mtgl_pkg;

  localparam int CoordW  = 16;
  localparam int CountW  = 16;
  localparam int ByteW   = 8;
  localparam int KindW   = 2;
  localparam int OffsetW = 19;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TEXT  = 1'b1;

  localparam logic [KindW-1:0] KIND_ASCII = 2'd0;
  localparam logic [KindW-1:0] KIND_HANZI = 2'd1;
  localparam logic [KindW-1:0] KIND_BAD   = 2'd2;

  localparam logic [ByteW-1:0] GB_BASE   = 8'hA1;
  localparam logic [6:0]       GB_ROW    = 7'd94;
  localparam logic [ByteW-1:0] CHAR_NUL  = 8'h00;
  localparam logic [ByteW-1:0] CHAR_CR   = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_LF   = 8'h0A;

  localparam logic [CoordW-1:0] LINE_STEP = 16'd20;
  localparam logic [CoordW-1:0] ASCII_ADV = 16'd8;
  localparam logic [CoordW-1:0] HANZI_ADV = 16'd16;
  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CountW-1:0] COUNT_SAT = 16'hFFFE;

  typedef struct packed {
    logic [CoordW-1:0]  glyph_x;
    logic [CoordW-1:0]  glyph_y;
    logic [KindW-1:0]   glyph_kind;
    logic [OffsetW-1:0] font_offset;
  } glyph_t;

  typedef struct packed {
    logic              opcode;
    logic [ByteW-1:0]  text_byte;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CountW-1:0] byte_limit;
  } item_t;

endpackage

// File: hw/rtl/mtgl_core.sv
module mtgl_core
  import mtgl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step_en,
  input  item_t  item,
  output logic   res_valid,
  output glyph_t res
);

  logic [CoordW-1:0] cursor_x_r, cursor_x_nxt;
  logic [CoordW-1:0] cursor_y_r, cursor_y_nxt;
  logic [CountW-1:0] bytes_used_r, bytes_used_nxt;
  logic [CountW-1:0] limit_held_r, limit_held_nxt;
  logic [ByteW-1:0]  lead_byte_r, lead_byte_nxt;
  logic              lead_pending_r, lead_pending_nxt;
  logic              finished_r, finished_nxt;

  logic [6:0]  lead_d;
  logic [6:0]  trail_d;
  logic [13:0] hanzi_idx;

  assign lead_d    = 7'(lead_byte_r - GB_BASE);
  assign trail_d   = 7'(item.text_byte - GB_BASE);
  assign hanzi_idx = 14'(lead_d) * 14'(GB_ROW) + 14'(trail_d);

  always_comb begin
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    bytes_used_nxt   = bytes_used_r;
    limit_held_nxt   = limit_held_r;
    lead_byte_nxt    = lead_byte_r;
    lead_pending_nxt = lead_pending_r;
    finished_nxt     = finished_r;
    res_valid        = 1'b0;
    res.glyph_x      = cursor_x_r;
    res.glyph_y      = cursor_y_r;
    res.glyph_kind   = KIND_ASCII;
    res.font_offset  = OffsetW'({item.text_byte, 4'b0000});

    if (item.opcode == OP_START) begin
      cursor_x_nxt     = item.start_x;
      cursor_y_nxt     = item.start_y;
      limit_held_nxt   = item.byte_limit;
      bytes_used_nxt   = '0;
      lead_byte_nxt    = '0;
      lead_pending_nxt = 1'b0;
      finished_nxt     = 1'b0;
    end else if (!finished_r) begin
      if (lead_pending_r) begin
        lead_pending_nxt = 1'b0;
        lead_byte_nxt    = '0;
        if (item.text_byte == CHAR_NUL) begin
          finished_nxt = 1'b1;
        end else begin
          res_valid = 1'b1;
          if (lead_byte_r < GB_BASE || item.text_byte < GB_BASE) begin
            res.glyph_kind  = KIND_BAD;
            res.font_offset = '0;
          end else begin
            res.glyph_kind  = KIND_HANZI;
            res.font_offset = {hanzi_idx, 5'b00000};
          end
          cursor_x_nxt   = cursor_x_r + HANZI_ADV;
          bytes_used_nxt = (bytes_used_r >= COUNT_SAT) ? COUNT_MAX
                                                       : bytes_used_r + CountW'(2);
        end
      end else if (item.text_byte == CHAR_NUL || bytes_used_r >= limit_held_r) begin
        finished_nxt = 1'b1;
      end else if (item.text_byte[ByteW-1]) begin
        lead_byte_nxt    = item.text_byte;
        lead_pending_nxt = 1'b1;
      end else begin
        bytes_used_nxt = bytes_used_r + CountW'(1);
        if (item.text_byte == CHAR_CR) begin
          cursor_x_nxt = '0;
        end else if (item.text_byte == CHAR_LF) begin
          cursor_x_nxt = '0;
          cursor_y_nxt = cursor_y_r + LINE_STEP;
        end else begin
          res_valid    = 1'b1;
          cursor_x_nxt = cursor_x_r + ASCII_ADV;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      bytes_used_r   <= '0;
      limit_held_r   <= '0;
      lead_byte_r    <= '0;
      lead_pending_r <= 1'b0;
      finished_r     <= 1'b1;
    end else if (step_en) begin
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      bytes_used_r   <= bytes_used_nxt;
      limit_held_r   <= limit_held_nxt;
      lead_byte_r    <= lead_byte_nxt;
      lead_pending_r <= lead_pending_nxt;
      finished_r     <= finished_nxt;
    end
  end

  a_pending_active: assert property (@(posedge clk) disable iff (!rst_n)
    lead_pending_r |-> !finished_r)
    else $error("lead pending on a finished string");

  a_pending_high: assert property (@(posedge clk) disable iff (!rst_n)
    lead_pending_r |-> lead_byte_r[ByteW-1])
    else $error("pending lead byte below 128");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.opcode == OP_START) |=>
      (!lead_pending_r && !finished_r && bytes_used_r == '0))
    else $error("start word did not open a clean string");

endmodule

// File: hw/rtl/mixed_text_glyph_layout_unit.sv
// Mixed ASCII / GB2312 text layout unit.
// Input channel (in_*): one word per byte of text, or a start word
// (in_opcode 0) that loads the cursor and byte limit and opens a string.
// Output channel (out_*): one glyph word per ASCII byte other than NUL,
// CR and LF, or per double-byte pair completed by a non-NUL byte; CR, LF,
// lead bytes, start words and string ends produce nothing.
// Throughput: one input word per cycle while in_ready is high. Cursor
// state updates in the accepting cycle; a glyph word enters the output
// queue as its word is accepted and is shown on out_* from the head entry.
// A two-entry output queue sits behind the step logic, so the block keeps
// accepting while one glyph waits on a stalled receiver. in_ready drops
// only when both entries are full and comes back the cycle after the
// receiver takes one.
// Reset: synchronous, active low. The output queue empties, the cursor,
// count and limit clear to zero and no string is active, so text words
// are ignored until a start word arrives.
module mixed_text_glyph_layout_unit
  import mtgl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [ByteW-1:0]   in_text_byte,
  input  logic [CoordW-1:0]  in_start_x,
  input  logic [CoordW-1:0]  in_start_y,
  input  logic [CountW-1:0]  in_byte_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CoordW-1:0]  out_glyph_x,
  output logic [CoordW-1:0]  out_glyph_y,
  output logic [KindW-1:0]   out_glyph_kind,
  output logic [OffsetW-1:0] out_font_offset
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   step_valid;
  item_t  item;
  glyph_t step_res;

  glyph_t head_r, head_nxt;
  glyph_t skid_r, skid_nxt;
  logic   head_v_r, head_v_nxt;
  logic   skid_v_r, skid_v_nxt;

  assign in_ready        = !skid_v_r;
  assign accept          = in_valid && in_ready;
  assign item.opcode     = in_opcode;
  assign item.text_byte  = in_text_byte;
  assign item.start_x    = in_start_x;
  assign item.start_y    = in_start_y;
  assign item.byte_limit = in_byte_limit;

  mtgl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept),
    .item      (item),
    .res_valid (step_valid),
    .res       (step_res)
  );

  assign push = accept && step_valid;
  assign pop  = head_v_r && out_ready;

  always_comb begin
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        head_nxt = step_res;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = step_res;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = step_res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = head_v_r;
  assign out_glyph_x     = head_r.glyph_x;
  assign out_glyph_y     = head_r.glyph_y;
  assign out_glyph_kind  = head_r.glyph_kind;
  assign out_font_offset = head_r.font_offset;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> head_v_r)
    else $error("skid entry held with empty head");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (head_v_r && !skid_v_r && head_r == $past(skid_r)))
    else $error("skid entry not moved to head on pop");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !head_v_r) |=> (head_v_r && head_r == $past(step_res)))
    else $error("glyph word lost on push into empty queue");

endmodule

// File: tb/sv/tb_mixed_text_glyph_layout_unit.sv
module tb_mixed_text_glyph_layout_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mtgl_pkg::*;

  localparam int AsciiBytes = 16;
  localparam int HanziBytes = 32;
  localparam logic [ByteW-1:0] HighByte = 8'h80;
  localparam int MaxReports = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_START;
  logic [ByteW-1:0] in_text_byte = '0;
  logic [CoordW-1:0] in_start_x = '0;
  logic [CoordW-1:0] in_start_y = '0;
  logic [CountW-1:0] in_byte_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CoordW-1:0] out_glyph_x;
  logic [CoordW-1:0] out_glyph_y;
  logic [KindW-1:0] out_glyph_kind;
  logic [OffsetW-1:0] out_font_offset;

  mixed_text_glyph_layout_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_text_byte(in_text_byte),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .in_byte_limit(in_byte_limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_glyph_x(out_glyph_x),
    .out_glyph_y(out_glyph_y),
    .out_glyph_kind(out_glyph_kind),
    .out_font_offset(out_font_offset)
  );

  always #5 clk = ~clk;

  // cursor shadow
  logic [CoordW-1:0] cur_x = '0;
  logic [CoordW-1:0] cur_y = '0;
  logic [CountW-1:0] used_cnt = '0;
  logic [CountW-1:0] limit_q = '0;
  logic [ByteW-1:0] lead_q = '0;
  logic lead_wait = 1'b0;
  logic str_done = 1'b1;

  item_t text_words[$];
  glyph_t pending_glyphs[$];
  item_t drv_word;
  glyph_t next_glyph;
  glyph_t want;
  int idle_pct = 0;
  int stall_pct = 0;
  int mism_cnt = 0;
  int words_taken = 0;
  int glyphs_seen = 0;
  int strings_opened = 0;

  function automatic bit layout_step(input item_t w, output glyph_t g);
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] lead;
    int idx;
    b = w.text_byte;
    g = '0;
    if (w.opcode == OP_START) begin
      cur_x = w.start_x;
      cur_y = w.start_y;
      limit_q = w.byte_limit;
      used_cnt = '0;
      lead_q = '0;
      lead_wait = 1'b0;
      str_done = 1'b0;
      return 1'b0;
    end
    if (str_done) return 1'b0;
    if (lead_wait) begin
      lead = lead_q;
      lead_wait = 1'b0;
      lead_q = '0;
      if (b == CHAR_NUL) begin
        str_done = 1'b1;
        return 1'b0;
      end
      g.glyph_x = cur_x;
      g.glyph_y = cur_y;
      if (lead < GB_BASE || b < GB_BASE) begin
        g.glyph_kind = KIND_BAD;
        g.font_offset = '0;
      end else begin
        idx = (int'(lead) - int'(GB_BASE)) * int'(GB_ROW) + (int'(b) - int'(GB_BASE));
        g.glyph_kind = KIND_HANZI;
        g.font_offset = OffsetW'(idx * HanziBytes);
      end
      cur_x = cur_x + HANZI_ADV;
      used_cnt = (used_cnt >= COUNT_SAT) ? COUNT_MAX : used_cnt + 16'd2;
      return 1'b1;
    end
    if (b == CHAR_NUL || used_cnt >= limit_q) begin
      str_done = 1'b1;
      return 1'b0;
    end
    if (b >= HighByte) begin
      lead_q = b;
      lead_wait = 1'b1;
      return 1'b0;
    end
    used_cnt = used_cnt + 16'd1;
    if (b == CHAR_CR) begin
      cur_x = '0;
      return 1'b0;
    end
    if (b == CHAR_LF) begin
      cur_x = '0;
      cur_y = cur_y + LINE_STEP;
      return 1'b0;
    end
    g.glyph_x = cur_x;
    g.glyph_y = cur_y;
    g.glyph_kind = KIND_ASCII;
    g.font_offset = OffsetW'(int'(b) * AsciiBytes);
    cur_x = cur_x + ASCII_ADV;
    return 1'b1;
  endfunction

  task automatic push_start(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                            input logic [CountW-1:0] lim);
    item_t w;
    w = '0;
    w.opcode = OP_START;
    w.text_byte = ByteW'($urandom);
    w.start_x = x;
    w.start_y = y;
    w.byte_limit = lim;
    text_words.push_back(w);
    strings_opened++;
  endtask

  task automatic push_text(input logic [ByteW-1:0] b);
    item_t w;
    w.opcode = OP_TEXT;
    w.text_byte = b;
    w.start_x = CoordW'($urandom);
    w.start_y = CoordW'($urandom);
    w.byte_limit = CountW'($urandom);
    text_words.push_back(w);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    if ($urandom_range(3) == 0) return CoordW'(16'hFFC0 + $urandom_range(63));
    return CoordW'($urandom);
  endfunction

  // strings of random content, mostly well formed; queues about n_words words
  task automatic queue_random_strings(input int n_words);
    int made;
    int len;
    int pick;
    logic [CountW-1:0] lim;
    made = 0;
    while (made < n_words) begin
      if ($urandom_range(19) == 0) begin
        push_text(ByteW'($urandom));
        continue;
      end
      pick = $urandom_range(9);
      if (pick == 0) lim = '0;
      else if (pick == 1) lim = COUNT_MAX;
      else if (pick == 2) lim = CountW'($urandom);
      else lim = CountW'($urandom_range(1, 40));
      push_start(rand_coord(), rand_coord(), lim);
      made++;
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          push_text(ByteW'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 45) begin
          push_text(ByteW'($urandom_range(8'h01, 8'h7F)));
        end else if (pick < 50) begin
          push_text(CHAR_CR);
        end else if (pick < 57) begin
          push_text(CHAR_LF);
        end else if (pick < 80) begin
          push_text(ByteW'($urandom_range(8'hA1, 8'hFF)));
          push_text(ByteW'($urandom_range(8'hA1, 8'hFF)));
          made++;
        end else if (pick < 88) begin
          push_text(ByteW'($urandom_range(8'h80, 8'hFF)));
          push_text(ByteW'($urandom_range(8'h01, 8'hFF)));
          made++;
        end else if (pick < 91) begin
          push_text(ByteW'($urandom_range(8'h80, 8'hFF)));
          push_text(CHAR_NUL);
          made++;
        end else if (pick < 93) begin
          push_text(CHAR_NUL);
        end else begin
          push_text(ByteW'($urandom));
        end
        made++;
      end
      if ($urandom_range(1) == 0) begin
        push_text(CHAR_NUL);
        made++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        words_taken++;
        if (layout_step(drv_word, next_glyph)) pending_glyphs.push_back(next_glyph);
      end
      if (!in_valid || in_ready) begin
        if (text_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drv_word = text_words.pop_front();
          in_valid <= 1'b1;
          in_opcode <= drv_word.opcode;
          in_text_byte <= drv_word.text_byte;
          in_start_x <= drv_word.start_x;
          in_start_y <= drv_word.start_y;
          in_byte_limit <= drv_word.byte_limit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      glyphs_seen++;
      if (pending_glyphs.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MaxReports)
          $display("unexpected glyph x=%0d y=%0d kind=%0d off=%0d", out_glyph_x,
                   out_glyph_y, out_glyph_kind, out_font_offset);
      end else begin
        want = pending_glyphs.pop_front();
        if (out_glyph_x !== want.glyph_x || out_glyph_y !== want.glyph_y ||
            out_glyph_kind !== want.glyph_kind || out_font_offset !== want.font_offset) begin
          mism_cnt++;
          if (mism_cnt <= MaxReports)
            $display({"glyph mismatch: exp x=%0d y=%0d kind=%0d off=%0d,",
                      " got x=%0d y=%0d kind=%0d off=%0d"},
                     want.glyph_x, want.glyph_y, want.glyph_kind, want.font_offset,
                     out_glyph_x, out_glyph_y, out_glyph_kind, out_font_offset);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int drain;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: no idling, directed cases first
    idle_pct = 0;
    stall_pct = 0;
    push_text(8'h41);
    push_start(16'd0, 16'd0, 16'd100);
    push_text(8'h41);
    push_text(8'h7F);
    push_text(8'h01);
    push_text(CHAR_CR);
    push_text(8'h7A);
    push_text(CHAR_LF);
    push_text(8'hA1); push_text(8'hA1);
    push_text(8'hF7); push_text(8'hFE);
    push_text(8'hFF); push_text(8'hFF);
    push_text(8'h80); push_text(8'h41);
    push_text(8'hB0); push_text(8'h80);
    push_text(8'h42);
    push_text(8'hC0); push_text(CHAR_NUL);
    push_text(8'h41);
    push_start(16'hFFF8, 16'hFFF0, 16'd0);
    push_text(8'h41);
    push_text(8'h41);
    push_start(16'hFFF8, 16'hFFF4, 16'd3);
    push_text(8'h61);
    push_text(CHAR_LF);
    push_text(8'hC0); push_text(8'hC1);
    push_text(8'h62);
    push_start(16'd1, 16'd2, 16'd10);
    push_text(8'hB5);
    push_start(16'd5, 16'd6, 16'd10);
    push_text(8'h42);
    push_text(CHAR_NUL);
    queue_random_strings(340);
    while (text_words.size() != 0) @(posedge clk);

    idle_pct = 81;
    stall_pct = 0;
    queue_random_strings(340);
    while (text_words.size() != 0) @(posedge clk);

    idle_pct = 0;
    stall_pct = 81;
    queue_random_strings(340);
    while (text_words.size() != 0) @(posedge clk);

    idle_pct = 21;
    stall_pct = 21;
    queue_random_strings(340);
    while (text_words.size() != 0 || in_valid) @(posedge clk);

    for (drain = 0; drain < 2000 && pending_glyphs.size() != 0; drain++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_glyphs.size() != 0) begin
      mism_cnt += pending_glyphs.size();
      $display("%0d glyphs never arrived", pending_glyphs.size());
    end

    $display("run: %0d words over %0d strings, %0d glyphs checked, %0d mismatches",
             words_taken, strings_opened, glyphs_seen, mism_cnt);
    if (mism_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
